@@ hdl/mss_pkg.sv @@
// Shared types and constants for the multi-stack shared store.
// Holds field widths, operation and status codes and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package mss_pkg;

	localparam int MODE_W   = 1;
	localparam int SID_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_F_W = 4;

	localparam logic [MODE_W-1:0] MODE_PUSH = 1'b0;
	localparam logic [MODE_W-1:0] MODE_POP  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		status_t               status;
		logic [VALUE_W-1:0]    popped_value;
		logic [SLOT_F_W-1:0]   slot;
	} res_t;

endpackage

@@ hdl/mss_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/multi_stack_shared_store_top.sv @@
// Top level of the multi-stack shared store: sequencer, free list and output stage.
// Depends on mss_pkg and mss_ram (data, link and stack-top memories).
// A push or any error gives its result from S_LOOK, once the stack-top memory has
// been read; a successful pop goes on to S_POP for the dependent reads of the link
// and data memories. One word is in work at a time: no input word is taken until
// the last one is through and the skid register is empty. Reset is asynchronous and
// needs no clearing pass: stack tops carry valid bits and a high-water counter
// stands in for the initial free list.
`timescale 1ns / 1ps

module multi_stack_shared_store_top
	import mss_pkg::*;
#(
	parameter int SLOTS      = 16,
	parameter int NUM_STACKS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // value[31:0]
	input  logic [2:0]  s_axis_tuser,  // mode[0], stack_id[2:1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // popped_value[31:0], slot[35:32], zero fill
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LINK_W = $clog2(SLOTS + 1);
	localparam int TOP_AW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

	typedef enum logic [1:0] {S_IDLE, S_LOOK, S_POP} state_t;

	state_t               state_q;
	logic [MODE_W-1:0]    mode_q;
	logic [SID_W-1:0]     sid_q;
	logic [VALUE_W-1:0]   val_q;
	logic [LINK_W-1:0]    top_q;
	logic [LINK_W-1:0]    free_head_q;
	logic [LINK_W-1:0]    hwm_q;
	logic [NUM_STACKS-1:0] top_vld_q;

	res_t out_q, skid_q, fin_res;
	logic out_valid_q, skid_valid_q, fin_valid;

	logic [TOP_AW+SID_W-1:0] sid_ext, sid_in_ext;
	logic [TOP_AW-1:0]       sid_addr;
	logic                    in_range;

	logic [LINK_W-1:0]  tops_rdata, link_rdata, top_rd, link_clean, push_next;
	logic [VALUE_W-1:0] data_rdata;
	logic               fresh, in_acc, drain;

	logic                tops_we, link_we, data_we;
	logic [LINK_W-1:0]   tops_wdata, link_wdata;
	logic [SLOT_W-1:0]   link_waddr, link_raddr, data_waddr;
	logic [LINK_W-1:0]   slot_sel;
	logic [LINK_W+SLOT_F_W-1:0] slot_ext;

	assign sid_ext    = {{TOP_AW{1'b0}}, sid_q};
	assign sid_in_ext = {{TOP_AW{1'b0}}, s_axis_tuser[2:1]};
	assign sid_addr   = sid_ext[TOP_AW-1:0];
	assign in_range   = sid_ext < (TOP_AW + SID_W)'(NUM_STACKS);

	assign top_rd     = (in_range && top_vld_q[sid_addr]) ? tops_rdata : NULL_LINK;
	assign link_clean = (link_rdata >= NULL_LINK) ? NULL_LINK : link_rdata;
	assign fresh      = free_head_q >= hwm_q;
	assign push_next  = fresh ? (free_head_q + LINK_W'(1)) : link_clean;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign drain  = out_valid_q && m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && !skid_valid_q;

	assign link_raddr = (state_q == S_IDLE) ? free_head_q[SLOT_W-1:0] : top_rd[SLOT_W-1:0];
	assign slot_ext   = {{SLOT_F_W{1'b0}}, slot_sel};

	always_comb begin
		tops_we    = 1'b0;
		tops_wdata = top_rd;
		link_we    = 1'b0;
		link_waddr = free_head_q[SLOT_W-1:0];
		link_wdata = top_rd;
		data_we    = 1'b0;
		data_waddr = free_head_q[SLOT_W-1:0];
		fin_valid  = 1'b0;
		slot_sel   = '0;
		fin_res.status       = STATUS_DONE;
		fin_res.popped_value = '0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_LOOK: begin
				if (mode_q == MODE_PUSH) begin
					fin_valid = 1'b1;
					if (!in_range || free_head_q >= NULL_LINK) begin
						fin_res.status = STATUS_OVERFLOW;
					end else begin
						tops_we    = 1'b1;
						tops_wdata = free_head_q;
						link_we    = 1'b1;
						data_we    = 1'b1;
						slot_sel   = free_head_q;
					end
				end else if (top_rd >= NULL_LINK) begin
					fin_valid      = 1'b1;
					fin_res.status = STATUS_UNDERFLOW;
				end
			end
			S_POP: begin
				fin_valid            = 1'b1;
				fin_res.popped_value = data_rdata;
				slot_sel             = top_q;
				tops_we              = 1'b1;
				tops_wdata           = link_clean;
				link_we              = 1'b1;
				link_waddr           = top_q[SLOT_W-1:0];
				link_wdata           = free_head_q;
			end
			default: begin
			end
		endcase
		fin_res.slot = slot_ext[SLOT_F_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_PUSH;
			sid_q       <= '0;
			val_q       <= '0;
			top_q       <= NULL_LINK;
			free_head_q <= '0;
			hwm_q       <= '0;
			top_vld_q   <= '0;
		end else begin
			if (tops_we) begin
				top_vld_q[sid_addr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mode_q  <= s_axis_tuser[0];
						sid_q   <= s_axis_tuser[2:1];
						val_q   <= s_axis_tdata;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (mode_q == MODE_PUSH) begin
						if (data_we) begin
							free_head_q <= push_next;
							if (fresh) begin
								hwm_q <= hwm_q + LINK_W'(1);
							end
						end
						state_q <= S_IDLE;
					end else if (top_rd >= NULL_LINK) begin
						state_q <= S_IDLE;
					end else begin
						top_q   <= top_rd;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					free_head_q <= top_q;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (!out_valid_q || drain) begin
			if (skid_valid_q) begin
				out_q        <= skid_q;
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (fin_valid) begin
				out_q       <= fin_res;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end else if (fin_valid) begin
			skid_q       <= fin_res;
			skid_valid_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {4'b0, out_q.slot, out_q.popped_value};

	mss_ram #(
		.WIDTH(LINK_W),
		.DEPTH(NUM_STACKS),
		.AW   (TOP_AW)
	) u_tops_ram (
		.clk  (clk),
		.we   (tops_we),
		.waddr(sid_addr),
		.wdata(tops_wdata),
		.raddr(sid_in_ext[TOP_AW-1:0]),
		.rdata(tops_rdata)
	);

	mss_ram #(
		.WIDTH(LINK_W),
		.DEPTH(SLOTS),
		.AW   (SLOT_W)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	mss_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(SLOTS),
		.AW   (SLOT_W)
	) u_data_ram (
		.clk  (clk),
		.we   (data_we),
		.waddr(data_waddr),
		.wdata(val_q),
		.raddr(top_rd[SLOT_W-1:0]),
		.rdata(data_rdata)
	);

endmodule

@@ hdl/mss_checker.sv @@
// Port-level checks for the multi-stack shared store, bound to the top level.
// Depends on mss_pkg for the status codes and the push mode code.
`timescale 1ns / 1ps

module mss_checker
	import mss_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [2:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a word was still in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STATUS_DONE || m_axis_tuser == STATUS_OVERFLOW
			|| m_axis_tuser == STATUS_UNDERFLOW))
		else $error("result carries an unknown status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STATUS_DONE |-> m_axis_tdata == 40'd0)
		else $error("error result carries a nonzero value or slot");

	a_push_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == MODE_PUSH && !m_axis_tvalid
		|=> ##1 m_axis_tvalid && m_axis_tdata[31:0] == 32'd0)
		else $error("push result missing or carries a popped value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result word changed");

endmodule

bind multi_stack_shared_store_top mss_checker u_mss_checker (.*);

@@ dv/multi_stack_shared_store_checker.sv @@
// Result checker for the multi-stack shared store testbench.
// Models the stacks, free list and slot store, predicts each result word and compares it.
// Depends on mss_pkg for the field widths, operation and status codes.
`timescale 1ns / 1ps

module multi_stack_shared_store_checker
	import mss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // value[31:0]
	input  logic [2:0]  s_axis_tuser,  // mode[0], stack_id[2:1]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,  // popped_value[31:0], slot[35:32], zero fill
	input  logic [1:0]  m_axis_tuser,  // status[1:0]
	output int          fail_count,
	output int          pending,
	output int          push_done,
	output int          pop_done,
	output int          overflows,
	output int          underflows
);

	localparam int NUM_SLOTS = 16;
	localparam int NUM_STK   = 4;
	localparam logic [4:0] LINK_NULL = 5'd16;

	logic [VALUE_W-1:0] slot_data [NUM_SLOTS];
	logic [4:0]         slot_link [NUM_SLOTS];
	logic [4:0]         stack_top [NUM_STK];
	logic [4:0]         free_head;
	res_t               stack_outcomes [$];

	initial begin
		fail_count = 0;
		push_done  = 0;
		pop_done   = 0;
		overflows  = 0;
		underflows = 0;
		pending    = 0;
	end

	function automatic res_t stack_op_outcome(input logic [MODE_W-1:0] mode,
			input logic [SID_W-1:0] sid, input logic [VALUE_W-1:0] val);
		res_t       r;
		logic [4:0] idx;
		r.status       = STATUS_DONE;
		r.popped_value = '0;
		r.slot         = '0;
		if (mode == MODE_PUSH) begin
			idx = free_head;
			if (int'(sid) >= NUM_STK || idx == LINK_NULL) begin
				r.status = STATUS_OVERFLOW;
			end else begin
				free_head      = slot_link[idx[3:0]];
				slot_link[idx[3:0]] = stack_top[sid];
				slot_data[idx[3:0]] = val;
				stack_top[sid] = idx;
				r.slot         = idx[3:0];
			end
		end else begin
			idx = (int'(sid) < NUM_STK) ? stack_top[sid] : LINK_NULL;
			if (idx == LINK_NULL) begin
				r.status = STATUS_UNDERFLOW;
			end else begin
				r.popped_value = slot_data[idx[3:0]];
				stack_top[sid] = slot_link[idx[3:0]];
				slot_link[idx[3:0]] = free_head;
				free_head      = idx;
				r.slot         = idx[3:0];
			end
		end
		return r;
	endfunction

	task automatic check_result();
		res_t want;
		if (stack_outcomes.size() == 0) begin
			$display("%0t: result word with nothing outstanding: tdata %h tuser %h",
				$time, m_axis_tdata, m_axis_tuser);
			fail_count++;
		end else begin
			want = stack_outcomes.pop_front();
			if (m_axis_tuser !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status,
					m_axis_tuser);
				fail_count++;
			end
			if (m_axis_tdata[31:0] !== want.popped_value) begin
				$display("%0t: popped_value expected %h actual %h", $time,
					want.popped_value, m_axis_tdata[31:0]);
				fail_count++;
			end
			if (m_axis_tdata[35:32] !== want.slot) begin
				$display("%0t: slot expected %0d actual %0d", $time, want.slot,
					m_axis_tdata[35:32]);
				fail_count++;
			end
			case (want.status)
				STATUS_OVERFLOW:  overflows++;
				STATUS_UNDERFLOW: underflows++;
				default: begin
					if (m_axis_tdata[31:0] === want.popped_value && want.popped_value == '0)
						push_done += 0;
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t r;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_data[i] = '0;
				slot_link[i] = 5'(i + 1);
			end
			slot_link[NUM_SLOTS-1] = LINK_NULL;
			for (int i = 0; i < NUM_STK; i++)
				stack_top[i] = LINK_NULL;
			free_head = '0;
			stack_outcomes.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (s_axis_tvalid && s_axis_tready) begin
				r = stack_op_outcome(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata);
				if (r.status == STATUS_DONE) begin
					if (s_axis_tuser[0] == MODE_PUSH)
						push_done++;
					else
						pop_done++;
				end
				stack_outcomes.push_back(r);
			end
			pending <= stack_outcomes.size();
		end
	end

endmodule

@@ dv/multi_stack_shared_store_top_tb.sv @@
// Testbench top for the multi-stack shared store: clock, reset, stimulus and verdict.
// Drives push and pop words with random gaps and back-pressure; the checker module
// in multi_stack_shared_store_checker.sv predicts and compares. Depends on mss_pkg.
`timescale 1ns / 1ps

module multi_stack_shared_store_top_tb;
	import mss_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int GAP_MAX      = 18;
	localparam int RANDOM_WORDS = 1750;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [31:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [39:0] m_tdata;
	wire  [1:0]  m_tuser;

	int fail_count;
	int pending;
	int push_done;
	int pop_done;
	int overflows;
	int underflows;
	int cycles = 0;
	int words_sent = 0;
	bit no_idle = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	multi_stack_shared_store_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	multi_stack_shared_store_checker u_outcome_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.fail_count    (fail_count),
		.pending       (pending),
		.push_done     (push_done),
		.pop_done      (pop_done),
		.overflows     (overflows),
		.underflows    (underflows)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.", cycles,
				pending);
			$display("multi_stack_shared_store_top_tb failed");
			$finish;
		end
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	task automatic send_op(input logic [MODE_W-1:0] mode, input logic [SID_W-1:0] sid,
			input logic [VALUE_W-1:0] val);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= {sid, mode};
		do @(posedge clk); while (!(s_tready && s_tvalid));
		words_sent++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h7FFF_FFFF;
			3:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int               len;
		int               push_pct;
		int               sent;
		bit               first;
		logic [MODE_W-1:0] mode;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pop of an empty stack, then one extreme value per stack and LIFO order on one.
		send_op(MODE_POP,  2'd0, 32'h0000_0000);
		send_op(MODE_PUSH, 2'd0, 32'h7FFF_FFFF);
		send_op(MODE_PUSH, 2'd1, 32'h8000_0000);
		send_op(MODE_PUSH, 2'd2, 32'hFFFF_FFFF);
		send_op(MODE_PUSH, 2'd3, 32'h0000_0000);
		send_op(MODE_PUSH, 2'd3, 32'h5555_5555);
		send_op(MODE_PUSH, 2'd3, 32'hAAAA_AAAA);
		send_op(MODE_POP,  2'd3, 32'hFFFF_FFFF);
		send_op(MODE_POP,  2'd3, 32'h0000_0000);
		send_op(MODE_POP,  2'd3, 32'h0000_0000);
		send_op(MODE_POP,  2'd2, 32'h0000_0000);
		send_op(MODE_POP,  2'd1, 32'h0000_0000);
		send_op(MODE_POP,  2'd0, 32'h0000_0000);
		send_op(MODE_POP,  2'd3, 32'h0000_0000);
		send_op(MODE_POP,  2'd1, 32'hFFFF_FFFF);

		// The first phase only pushes, so the store fills and overflows early on.
		sent  = 0;
		first = 1'b1;
		while (sent < RANDOM_WORDS) begin
			len = $urandom_range(30, 120);
			case ($urandom_range(0, 3))
				0:       push_pct = 100;
				1:       push_pct = 80;
				2:       push_pct = 50;
				default: push_pct = 20;
			endcase
			if (first) begin
				push_pct = 100;
				first    = 1'b0;
			end
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (len) begin
				mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
				send_op(mode, SID_W'($urandom_range(0, 3)), pick_value());
			end
			sent += len;
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		$display("Sent %0d words: %0d pushes and %0d pops completed,", words_sent,
			push_done, pop_done);
		$display("%0d overflows and %0d underflows reported.", overflows, underflows);
		if (fail_count == 0) begin
			$display("multi_stack_shared_store_top_tb passed");
		end else begin
			$display("multi_stack_shared_store_top_tb failed");
		end
		$finish;
	end

endmodule
